FILE: hdl/ucb_pkg.sv
// Shared types, constants and helper functions for the UCB1 bandit scheduler.
// No dependencies; imported by every module of the block.
package ucb_pkg;

   localparam int NUM_ARMS  = 64;
   localparam int ARM_W     = (NUM_ARMS > 1) ? $clog2(NUM_ARMS) : 1;
   localparam int ID_W      = 7;
   localparam int CNT_W     = 32;
   localparam int MASK_W    = 64;
   localparam int DIV_W     = 48;
   localparam int LN_W      = 21;
   localparam int SQ_W      = 24;
   localparam int SCORE_W   = 25;
   localparam int CSR_IDX_W = 2;

   localparam logic [CNT_W-1:0] CNT_MAX       = '1;
   localparam logic [31:0]      LFSR_TAPS     = 32'h8020_0003;
   localparam logic [15:0]      LN2_Q16       = 16'd45426;
   localparam logic [16:0]      Q16_ONE       = 17'h1_0000;
   localparam logic [CNT_W-1:0] SKIP_MIN_SEL  = 32'd10;
   localparam logic [CNT_W-1:0] REACH_MIN_SEL = 32'd100;
   localparam logic [CNT_W-1:0] EPS_LIMIT     = 32'd10;
   // ceil(2^35 / 10): (x * EPS_RECIP) >> 35 is x / 10 for any 32-bit x
   localparam logic [31:0]      EPS_RECIP     = 32'hCCCC_CCCD;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED   = 2'd1;

   localparam logic OP_SELECT = 1'b0;
   localparam logic OP_UPDATE = 1'b1;

   localparam logic [1:0] OC_FAIL        = 2'd0;
   localparam logic [1:0] OC_NOT_REACHED = 2'd1;
   localparam logic [1:0] OC_TRAPPED     = 2'd2;
   localparam logic [1:0] OC_COMPLETED   = 2'd3;

   typedef struct packed {
      logic [CNT_W-1:0] sel;
      logic [CNT_W-1:0] reach;
      logic [CNT_W-1:0] comp;
      logic [CNT_W-1:0] fail;
   } arm_cnt_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_UPD_RD, ST_UPD_WR,
      ST_RES_RD, ST_RES_CHK, ST_RES_DIV, ST_RES_END,
      ST_EPS, ST_EPS_DIV, ST_ACT_DIV, ST_PICK,
      ST_LN, ST_LOG,
      ST_UCB_RD, ST_UCB_CHK, ST_UCB_DIV1, ST_UCB_DIV2, ST_UCB_SQRT,
      ST_UCB_CMP, ST_UCB_TIE, ST_UCB_END,
      ST_DONE
   } sched_state_type;

   typedef enum logic [2:0] {
      LG_IDLE, LG_NORM, LG_SQ, LG_ACC, LG_MUL, LG_DONE
   } log_state_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

   function automatic logic [31:0] lfsr_step(input logic [31:0] s);
      logic [31:0] n;
      n = s >> 1;
      if (s[0]) begin
         n = n ^ LFSR_TAPS;
      end
      return n;
   endfunction

endpackage

FILE: hdl/ucb1_bandit_scenario_scheduler.sv
// UCB1 bandit scheduler top level: sequencer over the per-arm count memory.
// Update: reads the addressed arm, writes it back, then strobes the result (an
//   out-of-range id goes straight to the result strobe). Select: walks every arm,
//   with random draws (including the one-in-ten draw), two divides and a root per
//   scored arm, after the log; one item at a time, with all divides on the
//   shared serial divider. busy stays high meanwhile.
// Reset: synchronous, clears counts (via valid bits), mask to all ones, seed to 1.
//   The result strobe lasts one cycle and cannot be stalled.
// Depends on ucb_pkg, ucb_arm_mem, ucb_div, ucb_sqrt, ucb_log.
module ucb1_bandit_scenario_scheduler
   import ucb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_op,
   input  logic [ID_W-1:0]      req_scenario_id,
   input  logic [1:0]           req_outcome,
   output logic                 rsp_valid,
   output logic [ID_W-1:0]      rsp_chosen_id,
   output logic [CNT_W-1:0]     rsp_selected_count,
   output logic [CNT_W-1:0]     rsp_reached_count,
   output logic [CNT_W-1:0]     rsp_completed_count,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [MASK_W-1:0]    csr_data
);

   sched_state_type state_ff, state_in;

   // Control and datapath registers
   logic                rsp_valid_ff, rsp_valid_in;
   logic [MASK_W-1:0]   mask_ff;
   logic [31:0]         rnd_ff, rnd_in;
   logic [CNT_W-1:0]    total_ff, total_in;
   logic [1:0]          oc_ff, oc_in;
   logic [ARM_W-1:0]    upd_arm_ff, upd_arm_in;
   logic [ARM_W-1:0]    arm_ff, arm_in;
   logic [ARM_W-1:0]    best_ff, best_in;
   logic [ID_W-1:0]     cnt_ff, cnt_in;
   logic [ID_W-1:0]     active_ff, active_in;
   logic [ID_W-1:0]     pick_ff, pick_in;
   logic [LN_W-1:0]     lnv_ff, lnv_in;
   logic [16:0]         exploit_ff, exploit_in;
   logic [SCORE_W-1:0]  score_ff, score_in;
   logic [SCORE_W-1:0]  top_score_ff, top_score_in;
   logic [ID_W-1:0]     chosen_ff, chosen_in;
   logic [28:0]         eps_q_ff, eps_q_in;
   arm_cnt_type         cur_ff, cur_in;
   arm_cnt_type         res_ff, res_in;

   // Unit handshakes
   logic                mem_rd_en, mem_wr_en;
   logic [ARM_W-1:0]    mem_rd_addr;
   arm_cnt_type         mem_rd_data, mem_wr_data;
   logic                div_start, div_done;
   logic [DIV_W-1:0]    div_dividend, div_quo;
   logic [CNT_W-1:0]    div_divisor, div_rem;
   logic                sq_start, sq_done;
   logic [SQ_W-1:0]     sq_root;
   logic                log_start, log_done;
   logic [LN_W-1:0]     log_out;

   // Shared conditions
   logic                accept, id_ok, last_arm, arm_on;
   logic                res_cand, ucb_elig, fail_skip, reach_skip;
   logic [ID_W-1:0]     mask_pop;
   logic [31:0]         rnd_next;
   logic [35:0]         fail_x10, sel_x9;
   arm_cnt_type         upd_cnt;
   logic [SCORE_W-1:0]  score_sum;
   logic [63:0]         eps_prod;
   logic                eps_hit;

   function automatic logic [ID_W-1:0] popcount(input logic [MASK_W-1:0] m);
      logic [ID_W-1:0] n;
      n = '0;
      for (int i = 0; i < NUM_ARMS; i++) begin
         n = n + ID_W'(m[i]);
      end
      return n;
   endfunction

   assign accept   = start && !busy;
   assign id_ok    = (req_scenario_id != '0) && (req_scenario_id <= ID_W'(NUM_ARMS));
   assign last_arm = (arm_ff == ARM_W'(NUM_ARMS - 1));
   assign arm_on   = mask_ff[arm_ff];
   assign mask_pop = popcount(mask_ff);
   assign rnd_next = lfsr_step(rnd_ff);

   // One-in-ten draw: quotient by reciprocal multiply, then hit when the
   // stepped generator is an exact multiple of ten
   assign eps_prod = 64'(rnd_next) * 64'(EPS_RECIP);
   assign eps_hit  = (rnd_ff == CNT_W'(eps_q_ff) * EPS_LIMIT);

   // Reservoir candidate: enabled and never selected
   assign res_cand = arm_on && (mem_rd_data.sel == '0);

   // UCB eligibility: mostly-failing and never-reaching arms drop out
   assign fail_x10   = {4'b0, mem_rd_data.fail} * 36'd10;
   assign sel_x9     = {4'b0, mem_rd_data.sel} * 36'd9;
   assign fail_skip  = (mem_rd_data.sel >= SKIP_MIN_SEL) && (fail_x10 > sel_x9);
   assign reach_skip = (mem_rd_data.sel >= REACH_MIN_SEL) && (mem_rd_data.reach == '0);
   assign ucb_elig   = arm_on && (mem_rd_data.sel != '0) && !fail_skip && !reach_skip;

   assign score_sum = SCORE_W'(exploit_ff) + SCORE_W'(sq_root);

   // Saturating update of the addressed arm
   always_comb begin
      upd_cnt      = mem_rd_data;
      upd_cnt.sel  = sat_inc(mem_rd_data.sel);
      if (oc_ff == OC_FAIL) begin
         upd_cnt.fail = sat_inc(mem_rd_data.fail);
      end
      if (oc_ff == OC_TRAPPED || oc_ff == OC_COMPLETED) begin
         upd_cnt.reach = sat_inc(mem_rd_data.reach);
      end
      if (oc_ff == OC_COMPLETED) begin
         upd_cnt.comp = sat_inc(mem_rd_data.comp);
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_SELECT) state_in = ST_RES_RD;
               else if (id_ok)          state_in = ST_UPD_RD;
               else                     state_in = ST_DONE;
            end
         end
         ST_UPD_RD:  state_in = ST_UPD_WR;
         ST_UPD_WR:  state_in = ST_DONE;
         ST_RES_RD:  state_in = ST_RES_CHK;
         ST_RES_CHK: begin
            if (res_cand && cnt_ff != '0) state_in = ST_RES_DIV;
            else if (last_arm)            state_in = ST_RES_END;
            else                          state_in = ST_RES_RD;
         end
         ST_RES_DIV: begin
            if (div_done) state_in = last_arm ? ST_RES_END : ST_RES_RD;
         end
         ST_RES_END: state_in = (cnt_ff != '0) ? ST_DONE : ST_EPS;
         ST_EPS:     state_in = (active_ff != '0) ? ST_EPS_DIV : ST_LN;
         ST_EPS_DIV: begin
            if (!eps_hit)                   state_in = ST_LN;
            else if (active_ff <= ID_W'(1)) state_in = ST_PICK;
            else                            state_in = ST_ACT_DIV;
         end
         ST_ACT_DIV: if (div_done) state_in = ST_PICK;
         ST_PICK: begin
            if ((arm_on && pick_ff == '0) || last_arm) state_in = ST_DONE;
         end
         ST_LN:      state_in = (total_ff > 32'd1) ? ST_LOG : ST_UCB_RD;
         ST_LOG:     if (log_done) state_in = ST_UCB_RD;
         ST_UCB_RD:  state_in = ST_UCB_CHK;
         ST_UCB_CHK: begin
            if (ucb_elig)      state_in = ST_UCB_DIV1;
            else if (last_arm) state_in = ST_UCB_END;
            else               state_in = ST_UCB_RD;
         end
         ST_UCB_DIV1: begin
            if (div_done) state_in = (lnv_ff != '0) ? ST_UCB_DIV2 : ST_UCB_CMP;
         end
         ST_UCB_DIV2: if (div_done) state_in = ST_UCB_SQRT;
         ST_UCB_SQRT: if (sq_done) state_in = ST_UCB_CMP;
         ST_UCB_CMP: begin
            if (cnt_ff != '0 && score_ff == top_score_ff
                && !(score_ff > top_score_ff)) state_in = ST_UCB_TIE;
            else if (last_arm)                 state_in = ST_UCB_END;
            else                               state_in = ST_UCB_RD;
         end
         ST_UCB_TIE: begin
            if (div_done) state_in = last_arm ? ST_UCB_END : ST_UCB_RD;
         end
         ST_UCB_END: begin
            if (cnt_ff != '0 || active_ff == '0) state_in = ST_DONE;
            else if (active_ff <= ID_W'(1))       state_in = ST_PICK;
            else                                  state_in = ST_ACT_DIV;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and unit control
   always_comb begin
      rsp_valid_in  = 1'b0;
      rnd_in        = rnd_ff;
      total_in      = total_ff;
      oc_in         = oc_ff;
      upd_arm_in    = upd_arm_ff;
      arm_in        = arm_ff;
      best_in       = best_ff;
      cnt_in        = cnt_ff;
      active_in     = active_ff;
      pick_in       = pick_ff;
      lnv_in        = lnv_ff;
      exploit_in    = exploit_ff;
      score_in      = score_ff;
      top_score_in  = top_score_ff;
      chosen_in     = chosen_ff;
      eps_q_in      = eps_q_ff;
      cur_in        = cur_ff;
      res_in        = res_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = arm_ff;
      mem_wr_en     = 1'b0;
      mem_wr_data   = upd_cnt;
      div_start     = 1'b0;
      div_dividend  = DIV_W'(rnd_next);
      div_divisor   = CNT_W'(cnt_ff + 1'b1);
      sq_start      = 1'b0;
      log_start     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // a zero generator state is replaced by one before each item
               if (rnd_ff == '0) rnd_in = 32'd1;
               oc_in      = req_outcome;
               upd_arm_in = ARM_W'(req_scenario_id - 1'b1);
               arm_in     = '0;
               cnt_in     = '0;
               chosen_in  = '0;
               res_in     = '0;
            end
         end
         ST_UPD_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = upd_arm_ff;
         end
         ST_UPD_WR: begin
            mem_wr_en = 1'b1;
            res_in    = upd_cnt;
            total_in  = sat_inc(total_ff);
         end
         ST_RES_RD: mem_rd_en = 1'b1;
         ST_RES_CHK: begin
            if (res_cand) begin
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == '0) begin
                  best_in = arm_ff;
               end else begin
                  // draw below the new count
                  div_start = 1'b1;
                  rnd_in    = rnd_next;
               end
            end
            if (!(res_cand && cnt_ff != '0) && !last_arm) arm_in = arm_ff + 1'b1;
         end
         ST_RES_DIV: begin
            if (div_done) begin
               if (div_rem == '0) best_in = arm_ff;
               if (!last_arm) arm_in = arm_ff + 1'b1;
            end
         end
         ST_RES_END: begin
            // only a reservoir hit picks here; otherwise keep zero
            if (cnt_ff != '0) chosen_in = ID_W'(best_ff) + 1'b1;
            active_in = mask_pop;
         end
         ST_EPS: begin
            if (active_ff != '0) begin
               // step the generator and latch its quotient by ten
               eps_q_in = eps_prod[63:35];
               rnd_in   = rnd_next;
            end
         end
         ST_EPS_DIV: begin
            arm_in  = '0;
            pick_in = '0;
            if (eps_hit && active_ff > ID_W'(1)) begin
               div_start   = 1'b1;
               div_divisor = CNT_W'(active_ff);
               rnd_in      = rnd_next;
            end
         end
         ST_ACT_DIV: begin
            arm_in  = '0;
            pick_in = div_rem[ID_W-1:0];
         end
         ST_PICK: begin
            if (arm_on) begin
               if (pick_ff == '0) chosen_in = ID_W'(arm_ff) + 1'b1;
               else               pick_in   = pick_ff - 1'b1;
            end
            arm_in = arm_ff + 1'b1;
         end
         ST_LN: begin
            arm_in = '0;
            lnv_in = '0;
            if (total_ff > 32'd1) log_start = 1'b1;
         end
         ST_LOG: if (log_done) lnv_in = log_out;
         ST_UCB_RD: mem_rd_en = 1'b1;
         ST_UCB_CHK: begin
            cur_in = mem_rd_data;
            if (ucb_elig) begin
               div_start    = 1'b1;
               div_dividend = DIV_W'({mem_rd_data.reach, 16'b0});
               div_divisor  = mem_rd_data.sel;
            end else if (!last_arm) begin
               arm_in = arm_ff + 1'b1;
            end
         end
         ST_UCB_DIV1: begin
            if (div_done) begin
               exploit_in = (div_quo[DIV_W-1:16] != '0) ? 17'd0
                          : 17'(Q16_ONE - {1'b0, div_quo[15:0]});
               score_in   = (div_quo[DIV_W-1:16] != '0) ? '0
                          : SCORE_W'(Q16_ONE - {1'b0, div_quo[15:0]});
               if (lnv_ff != '0) begin
                  div_start    = 1'b1;
                  div_dividend = DIV_W'({lnv_ff, 1'b0, 16'b0});
                  div_divisor  = cur_ff.sel;
               end
            end
         end
         ST_UCB_DIV2: if (div_done) sq_start = 1'b1;
         ST_UCB_SQRT: if (sq_done) score_in = score_sum;
         ST_UCB_CMP: begin
            if (cnt_ff == '0 || score_ff > top_score_ff) begin
               top_score_in = score_ff;
               best_in      = arm_ff;
               cnt_in       = ID_W'(1);
               if (!last_arm) arm_in = arm_ff + 1'b1;
            end else if (score_ff == top_score_ff) begin
               cnt_in    = cnt_ff + 1'b1;
               div_start = 1'b1;
               rnd_in    = rnd_next;
            end else if (!last_arm) begin
               arm_in = arm_ff + 1'b1;
            end
         end
         ST_UCB_TIE: begin
            if (div_done) begin
               if (div_rem == '0) best_in = arm_ff;
               if (!last_arm) arm_in = arm_ff + 1'b1;
            end
         end
         ST_UCB_END: begin
            arm_in  = '0;
            pick_in = '0;
            if (cnt_ff != '0) begin
               chosen_in = ID_W'(best_ff) + 1'b1;
            end else if (active_ff > ID_W'(1)) begin
               div_start   = 1'b1;
               div_divisor = CNT_W'(active_ff);
               rnd_in      = rnd_next;
            end
         end
         ST_DONE: rsp_valid_in = 1'b1;
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mask_ff      <= '1;
         rnd_ff       <= 32'd1;
         total_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         total_ff     <= total_in;
         rnd_ff       <= rnd_in;
         // a seed write also loads the generator
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_ENABLE) mask_ff <= csr_data;
            if (csr_index == CSR_SEED)   rnd_ff  <= csr_data[31:0];
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      oc_ff         <= oc_in;
      upd_arm_ff    <= upd_arm_in;
      arm_ff        <= arm_in;
      best_ff       <= best_in;
      cnt_ff        <= cnt_in;
      active_ff     <= active_in;
      pick_ff       <= pick_in;
      lnv_ff        <= lnv_in;
      exploit_ff    <= exploit_in;
      score_ff      <= score_in;
      top_score_ff  <= top_score_in;
      chosen_ff     <= chosen_in;
      eps_q_ff      <= eps_q_in;
      cur_ff        <= cur_in;
      res_ff        <= res_in;
   end

   ucb_arm_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (upd_arm_ff),
      .wr_data (mem_wr_data)
   );

   ucb_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   ucb_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (div_quo),
      .done     (sq_done),
      .root     (sq_root)
   );

   ucb_log u_log (
      .clock  (clock),
      .reset  (reset),
      .start  (log_start),
      .value  (total_ff),
      .done   (log_done),
      .ln_q16 (log_out)
   );

   assign busy                = (state_ff != ST_IDLE);
   assign csr_ready           = !busy;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_chosen_id       = chosen_ff;
   assign rsp_selected_count  = res_ff.sel;
   assign rsp_reached_count   = res_ff.reach;
   assign rsp_completed_count = res_ff.comp;

   // Result strobe is a single-cycle transfer
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // An accepted item occupies the sequencer
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted item did not raise busy");

   // A select never reports counts
   a_select_no_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_chosen_id != '0 |-> rsp_selected_count == '0)
      else $error("select result carries counts");

   // Memory writes happen only in the update write-back step
   a_write_in_update: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> state_ff == ST_UPD_WR && $past(state_ff) == ST_UPD_RD)
      else $error("count memory written outside update");

endmodule

FILE: hdl/ucb_arm_mem.sv
// Per-arm count store: one synchronous RAM entry per arm, registered read.
// Valid bits make unwritten entries read as zero. Depends on ucb_pkg.
module ucb_arm_mem
   import ucb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [ARM_W-1:0] rd_addr,
   output arm_cnt_type      rd_data,
   input  logic             wr_en,
   input  logic [ARM_W-1:0] wr_addr,
   input  arm_cnt_type      wr_data
);

   arm_cnt_type             mem [NUM_ARMS];
   logic [NUM_ARMS-1:0]     valid_ff;
   arm_cnt_type             q_ff;
   logic                    q_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         q_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            q_vld_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = q_vld_ff ? q_ff : '0;

endmodule

FILE: hdl/ucb_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on ucb_pkg.
module ucb_div
   import ucb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [CNT_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient,
   output logic [CNT_W-1:0] remainder
);

   localparam int STEP_W = $clog2(DIV_W + 1);

   logic              run_ff;
   logic [STEP_W-1:0] step_ff;
   logic              done_ff;
   logic [DIV_W-1:0]  quo_ff;
   logic [CNT_W-1:0]  rem_ff;
   logic [CNT_W-1:0]  dvs_ff;
   logic [CNT_W:0]    part;
   logic [CNT_W:0]    diff;

   assign part = {rem_ff, quo_ff[DIV_W-1]};
   assign diff = part - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            step_ff <= '0;
         end else if (run_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (run_ff) begin
         if (!diff[CNT_W]) begin
            rem_ff <= diff[CNT_W-1:0];
            quo_ff <= {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_ff <= part[CNT_W-1:0];
            quo_ff <= {quo_ff[DIV_W-2:0], 1'b0};
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

FILE: hdl/ucb_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on ucb_pkg.
module ucb_sqrt
   import ucb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] radicand,
   output logic             done,
   output logic [SQ_W-1:0]  root
);

   localparam int STEP_W = $clog2(SQ_W + 1);
   localparam int REM_W  = SQ_W + 2;

   logic              run_ff;
   logic              done_ff;
   logic [STEP_W-1:0] step_ff;
   logic [DIV_W-1:0]  rad_ff;
   logic [SQ_W-1:0]   root_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [REM_W-1:0]  part;
   logic [REM_W-1:0]  trial;

   assign part  = {rem_ff[REM_W-3:0], rad_ff[DIV_W-1 -: 2]};
   assign trial = {root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            step_ff <= '0;
         end else if (run_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(SQ_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         root_ff <= '0;
         rem_ff  <= '0;
      end else if (run_ff) begin
         rad_ff <= {rad_ff[DIV_W-3:0], 2'b00};
         if (part >= trial) begin
            rem_ff  <= part - trial;
            root_ff <= {root_ff[SQ_W-2:0], 1'b1};
         end else begin
            rem_ff  <= part;
            root_ff <= {root_ff[SQ_W-2:0], 1'b0};
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

FILE: hdl/ucb_log.sv
// Natural log in Q16 of a 32-bit count: normalize, 16 squarings, scale by ln 2.
// Depends on ucb_pkg.
module ucb_log
   import ucb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [CNT_W-1:0] value,
   output logic             done,
   output logic [LN_W-1:0]  ln_q16
);

   log_state_type state_ff, state_in;
   logic [4:0]    k_ff;
   logic [3:0]    iter_ff;
   logic [31:0]   m_ff;
   logic [63:0]   sq_ff;
   logic [15:0]   frac_ff;
   logic [36:0]   prod_ff;
   logic [32:0]   t;

   assign t = sq_ff[63:31];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         LG_IDLE: if (start) state_in = LG_NORM;
         LG_NORM: if (m_ff[31]) state_in = LG_SQ;
         LG_SQ:   state_in = LG_ACC;
         LG_ACC:  state_in = (iter_ff == 4'd15) ? LG_MUL : LG_SQ;
         LG_MUL:  state_in = LG_DONE;
         LG_DONE: state_in = LG_IDLE;
         default: state_in = LG_IDLE;
      endcase
   end

   always_comb begin
      done   = (state_ff == LG_DONE);
      ln_q16 = prod_ff[36:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LG_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         LG_IDLE: begin
            m_ff    <= value;
            k_ff    <= 5'd31;
            iter_ff <= '0;
            frac_ff <= '0;
         end
         LG_NORM: begin
            if (!m_ff[31]) begin
               m_ff <= {m_ff[30:0], 1'b0};
               k_ff <= k_ff - 1'b1;
            end
         end
         LG_SQ: sq_ff <= m_ff * m_ff;
         LG_ACC: begin
            frac_ff <= {frac_ff[14:0], t[32]};
            m_ff    <= t[32] ? t[32:1] : t[31:0];
            iter_ff <= iter_ff + 1'b1;
         end
         LG_MUL: prod_ff <= {k_ff, frac_ff} * LN2_Q16;
         default: ;
      endcase
   end

endmodule
